// ===== design/fconv_pkg.sv =====
// Package for the streaming full 2D convolution block.
// Holds shared widths, register codes and reset values, the register struct
// and the kernel dimension clamp. No dependencies.
package fconv_pkg;

    // Default values for the top level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int KERNEL_MAX_DEF = 5;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int COEFF_BITS_DEF = 8;

    // Fixed limits and field widths
    localparam int MAX_HEIGHT  = 4096;
    localparam int PIXEL_W     = 8;
    localparam int SUM_W       = 21;
    localparam int LANE_W      = 8;
    localparam int CF_W        = LANE_W + 1;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int KDIM_W      = 3;
    localparam int COEFF_WORDS = 4;
    localparam int COEFF_LANES = 32;

    // APB register port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_ROWS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_COLS  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_0      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_1      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_2      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COEFF_3      = 3'd7;

    // Reset values
    localparam logic [WIDTH_W-1:0]    RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [KDIM_W-1:0]     RST_KERNEL_ROWS  = 3'd3;
    localparam logic [KDIM_W-1:0]     RST_KERNEL_COLS  = 3'd3;
    localparam logic [APB_DATA_W-1:0] RST_COEFF        = 64'h0101_0101_0101_0101;

    // Raw register contents as written
    typedef struct packed {
        logic [WIDTH_W-1:0]                    image_width;
        logic [HEIGHT_W-1:0]                   image_height;
        logic [KDIM_W-1:0]                     kernel_rows;
        logic [KDIM_W-1:0]                     kernel_cols;
        logic [COEFF_WORDS-1:0][APB_DATA_W-1:0] coeff;
    } t_cfg;

    // Clamp a kernel dimension to 1..kmax
    function automatic logic [KDIM_W-1:0] sat_kdim(input logic [KDIM_W-1:0] v,
                                                   input int kmax);
        logic [KDIM_W-1:0] res;
        if (v == '0) begin
            res = KDIM_W'(1);
        end else if (int'(v) > kmax) begin
            res = KDIM_W'(kmax);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== design/fconv_if.sv =====
// Stream interfaces of the convolution block: pixel requests in, results out.
// Depends on fconv_pkg for the payload widths.
interface fconv_pix_if;
    import fconv_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface fconv_res_if;
    import fconv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum;
    logic                    frame_end;
    modport source (output valid, output sum, output frame_end, input ready);
    modport sink   (input valid, input sum, input frame_end, output ready);
endinterface

// ===== design/fconv_cfg.sv =====
// APB register bank of the convolution block: geometry and packed coefficients.
// Depends on fconv_pkg.
module fconv_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fconv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fconv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fconv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output fconv_pkg::t_cfg                   o_cfg
);
    import fconv_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    // 64-bit registers sit on an 8-byte pitch
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.kernel_rows  <= RST_KERNEL_ROWS;
            r_cfg.kernel_cols  <= RST_KERNEL_COLS;
            r_cfg.coeff        <= {COEFF_WORDS{RST_COEFF}};
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[HEIGHT_W-1:0];
                REG_KERNEL_ROWS:  r_cfg.kernel_rows  <= pwdata[KDIM_W-1:0];
                REG_KERNEL_COLS:  r_cfg.kernel_cols  <= pwdata[KDIM_W-1:0];
                REG_COEFF_0:      r_cfg.coeff[0]     <= pwdata;
                REG_COEFF_1:      r_cfg.coeff[1]     <= pwdata;
                REG_COEFF_2:      r_cfg.coeff[2]     <= pwdata;
                REG_COEFF_3:      r_cfg.coeff[3]     <= pwdata;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_cfg.image_height);
            REG_KERNEL_ROWS:  prdata = APB_DATA_W'(r_cfg.kernel_rows);
            REG_KERNEL_COLS:  prdata = APB_DATA_W'(r_cfg.kernel_cols);
            REG_COEFF_0:      prdata = r_cfg.coeff[0];
            REG_COEFF_1:      prdata = r_cfg.coeff[1];
            REG_COEFF_2:      prdata = r_cfg.coeff[2];
            REG_COEFF_3:      prdata = r_cfg.coeff[3];
        endcase
    end

endmodule

// ===== design/fconv_line_ram.sv =====
// One line store: simple dual-port RAM, one write and one registered read.
// No dependencies.
module fconv_line_ram #(
    parameter int DEPTH = 1028,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== design/fconv_front.sv =====
// Front end: position counters, zero padding, line stores and the pixel window.
// Depends on fconv_pkg, fconv_if and fconv_line_ram.
module fconv_front #(
    parameter int MAX_WIDTH  = fconv_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_MAX = fconv_pkg::KERNEL_MAX_DEF,
    parameter int PIXEL_BITS = fconv_pkg::PIXEL_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    fconv_pix_if.sink                                     i_pix,
    input  fconv_pkg::t_cfg                               i_cfg,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [KERNEL_MAX*KERNEL_MAX-1:0][PIXEL_BITS-1:0] o_win,
    output logic [KERNEL_MAX-1:0]                         o_jmask,
    output logic                                          o_fend
);
    import fconv_pkg::*;

    localparam int K        = KERNEL_MAX;
    localparam int NTAP     = K * K;
    localparam int LINE_LEN = MAX_WIDTH + K - 1;
    localparam int COL_W    = $clog2(LINE_LEN + 1);
    localparam int ADDR_W   = $clog2(LINE_LEN);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + K);
    localparam int NLANE    = (K > 1) ? K - 1 : 1;
    localparam int PB       = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;

    // Geometry after clamping
    logic [COL_W-1:0]  w_sat, wext;
    logic [ROW_W-1:0]  h_sat, hext;
    logic [KDIM_W-1:0] r_sat, c_sat;

    // Position counters
    logic [COL_W-1:0] r_col, n_col, cur_j;
    logic [ROW_W-1:0] r_row, n_row, row_t, cur_i;
    logic             last_col, last_row;

    // Handshake
    logic accept, a_ready, a_adv, b_ready;

    // Stage A: request registered, line store read in flight
    logic                  r_a_valid;
    logic [PIXEL_BITS-1:0] r_a_px;
    logic                  r_a_inside;
    logic [K-1:0]          r_a_rowok, n_rowok;
    logic [K-1:0]          r_a_jmask, n_jmask;
    logic [COL_W-1:0]      r_a_j;
    logic                  r_a_fend;
    logic [NLANE-1:0]      r_a_hit, n_hit;
    logic [PIXEL_BITS-1:0] r_a_fwd [NLANE];

    // Stage B: window holds the item
    logic                  r_b_valid;
    logic [K-1:0]          r_b_jmask;
    logic                  r_b_fend;
    logic [NTAP-1:0][PIXEL_BITS-1:0] r_win, n_win;

    // Line store ports and the column of new pixels
    logic [NLANE-1:0]      lane_we, mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [PIXEL_BITS-1:0] mem_wdata [NLANE];
    logic [PIXEL_BITS-1:0] mem_q     [NLANE];
    logic [PIXEL_BITS-1:0] col       [K];

    // Clearing pass after reset
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Clamp the geometry registers
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_sat = COL_W'(1);
        end else if (32'(i_cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_sat = COL_W'(MAX_WIDTH);
        end else begin
            w_sat = COL_W'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            h_sat = ROW_W'(1);
        end else if (32'(i_cfg.image_height) > 32'(MAX_HEIGHT)) begin
            h_sat = ROW_W'(MAX_HEIGHT);
        end else begin
            h_sat = ROW_W'(i_cfg.image_height);
        end
        r_sat = sat_kdim(i_cfg.kernel_rows, K);
        c_sat = sat_kdim(i_cfg.kernel_cols, K);
        wext  = w_sat + COL_W'(c_sat) - COL_W'(1);
        hext  = h_sat + ROW_W'(r_sat) - ROW_W'(1);
    end

    // Current position, wrapped if the grid shrank, and the next one
    always_comb begin
        if (r_col >= wext) begin
            cur_j = '0;
            row_t = r_row + ROW_W'(1);
        end else begin
            cur_j = r_col;
            row_t = r_row;
        end
        cur_i    = (row_t >= hext) ? '0 : row_t;
        last_col = (cur_j == wext - COL_W'(1));
        last_row = (cur_i == hext - ROW_W'(1));
        n_col    = last_col ? '0 : cur_j + COL_W'(1);
        if (last_col) begin
            n_row = last_row ? '0 : cur_i + ROW_W'(1);
        end else begin
            n_row = cur_i;
        end
        for (int a = 0; a < K; a++) begin
            n_rowok[a] = (32'(cur_i) >= 32'(a));
            n_jmask[a] = (32'(cur_j) >= 32'(a));
        end
    end

    // Pipeline handshake
    assign b_ready     = !r_b_valid || i_ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign a_adv       = r_a_valid && b_ready;
    assign i_pix.ready = a_ready && !r_clr_busy;
    assign accept      = i_pix.valid && i_pix.ready;

    // New column: padded pixel on top, line stores below, with write-read bypass
    always_comb begin
        col[0] = r_a_inside ? r_a_px : '0;
        for (int a = 1; a < K; a++) begin
            if (!r_a_rowok[a]) begin
                col[a] = '0;
            end else if (r_a_hit[a-1]) begin
                col[a] = r_a_fwd[a-1];
            end else begin
                col[a] = mem_q[a-1];
            end
        end
        for (int l = 0; l < NLANE; l++) begin
            lane_we[l] = ((l + 1) < int'(r_sat));
            n_hit[l]   = a_adv && lane_we[l] && (r_a_j == cur_j);
            mem_we[l]  = r_clr_busy || (a_adv && lane_we[l]);
            mem_wdata[l] = r_clr_busy ? '0 : col[l];
        end
        mem_waddr = r_clr_busy ? r_clr_addr : r_a_j[ADDR_W-1:0];
    end

    // Window shift within the active kernel shape
    always_comb begin
        n_win = r_win;
        for (int a = 0; a < K; a++) begin
            for (int b = 0; b < K; b++) begin
                if ((a < int'(r_sat)) && (b < int'(c_sat))) begin
                    if (b == 0) begin
                        n_win[a*K] = col[a];
                    end else begin
                        n_win[a*K+b] = r_win[a*K+b-1];
                    end
                end
            end
        end
    end

    // Line stores, one per kernel row above the current one
    for (genvar l = 0; l < NLANE; l++) begin : g_line
        fconv_line_ram #(
            .DEPTH (LINE_LEN),
            .WIDTH (PIXEL_BITS)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (mem_we[l]),
            .i_waddr (mem_waddr),
            .i_wdata (mem_wdata[l]),
            .i_re    (accept),
            .i_raddr (cur_j[ADDR_W-1:0]),
            .o_rdata (mem_q[l])
        );
    end

    // Clearing pass and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(LINE_LEN - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Stage A control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= accept;
        end
    end

    // Stage A payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_px     <= PIXEL_BITS'(i_pix.pixel[PB-1:0]);
            r_a_inside <= (cur_i < h_sat) && (cur_j < w_sat);
            r_a_rowok  <= n_rowok;
            r_a_jmask  <= n_jmask;
            r_a_j      <= cur_j;
            r_a_fend   <= last_col && last_row;
            r_a_hit    <= n_hit;
            for (int l = 0; l < NLANE; l++) begin
                r_a_fwd[l] <= col[l];
            end
        end
    end

    // Stage B control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_win     <= '0;
        end else begin
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (a_adv) begin
                r_win <= n_win;
            end
        end
    end

    // Stage B payload
    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_jmask <= r_a_jmask;
            r_b_fend  <= r_a_fend;
        end
    end

    assign o_valid = r_b_valid;
    assign o_win   = r_win;
    assign o_jmask = r_b_jmask;
    assign o_fend  = r_b_fend;

endmodule

// ===== design/fconv_mac.sv =====
// Multiply-accumulate back end: tap products, row sums, total and result register.
// Depends on fconv_pkg and fconv_if.
module fconv_mac #(
    parameter int KERNEL_MAX = fconv_pkg::KERNEL_MAX_DEF,
    parameter int PIXEL_BITS = fconv_pkg::PIXEL_BITS_DEF,
    parameter int COEFF_BITS = fconv_pkg::COEFF_BITS_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  fconv_pkg::t_cfg                                  i_cfg,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic [KERNEL_MAX*KERNEL_MAX-1:0][PIXEL_BITS-1:0] i_win,
    input  logic [KERNEL_MAX-1:0]                            i_jmask,
    input  logic                                             i_fend,
    fconv_res_if.source                                      o_res
);
    import fconv_pkg::*;

    localparam int K      = KERNEL_MAX;
    localparam int NTAP   = K * K;
    localparam int PROD_W = PIXEL_BITS + 1 + CF_W;
    localparam int ACC_W  = PROD_W + 6;
    localparam int EXT_W  = (ACC_W > SUM_W) ? ACC_W : SUM_W;
    localparam bit SGN    = (COEFF_BITS <= LANE_W);
    localparam int SB     = (COEFF_BITS > LANE_W) ? LANE_W - 1 : COEFF_BITS - 1;

    logic [KDIM_W-1:0] r_sat, c_sat;
    logic              p_ready, s_ready, o_free;

    logic signed [PROD_W-1:0] n_prod [NTAP];
    logic signed [PROD_W-1:0] r_prod [NTAP];
    logic                     r_p_valid, r_p_fend;

    logic signed [EXT_W-1:0]  n_rsum [K];
    logic signed [EXT_W-1:0]  r_rsum [K];
    logic                     r_s_valid, r_s_fend;

    logic signed [EXT_W-1:0]  n_total;
    logic signed [SUM_W-1:0]  r_o_sum;
    logic                     r_o_valid, r_o_fend;

    // Coefficient of tap n: low COEFF_BITS of its byte lane, lanes past the last read zero
    function automatic logic signed [CF_W-1:0] coeff_at(input t_cfg cfg, input int n);
        logic [LANE_W-1:0] lane;
        logic [CF_W-1:0]   cf;
        logic [1:0]        wsel;
        logic [2:0]        bsel;
        lane = '0;
        cf   = '0;
        wsel = 2'(n >> 3);
        bsel = 3'(n);
        if (n < COEFF_LANES) begin
            lane = cfg.coeff[wsel][{bsel, 3'b000} +: LANE_W];
            for (int k = 0; k < LANE_W; k++) begin
                cf[k] = (k < COEFF_BITS) ? lane[k] : (SGN ? lane[SB] : 1'b0);
            end
            cf[CF_W-1] = SGN ? lane[SB] : 1'b0;
        end
        return $signed(cf);
    endfunction

    assign r_sat = sat_kdim(i_cfg.kernel_rows, K);
    assign c_sat = sat_kdim(i_cfg.kernel_cols, K);

    // Stage handshake
    assign o_free  = !r_o_valid || o_res.ready;
    assign s_ready = !r_s_valid || o_free;
    assign p_ready = !r_p_valid || s_ready;
    assign o_ready = p_ready;

    // Tap products, taps outside the kernel or left of the image give zero
    always_comb begin
        for (int a = 0; a < K; a++) begin
            for (int b = 0; b < K; b++) begin
                if ((a < int'(r_sat)) && (b < int'(c_sat)) && i_jmask[b]) begin
                    n_prod[a*K+b] = $signed(PROD_W'({1'b0, i_win[a*K+b]}))
                                  * PROD_W'(coeff_at(i_cfg, a*K+b));
                end else begin
                    n_prod[a*K+b] = '0;
                end
            end
        end
    end

    // Row sums
    always_comb begin
        logic signed [EXT_W-1:0] acc;
        for (int a = 0; a < K; a++) begin
            acc = '0;
            for (int b = 0; b < K; b++) begin
                acc = acc + EXT_W'(r_prod[a*K+b]);
            end
            n_rsum[a] = acc;
        end
    end

    // Total over rows
    always_comb begin
        n_total = '0;
        for (int a = 0; a < K; a++) begin
            n_total = n_total + r_rsum[a];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_valid <= i_valid;
            end
            if (s_ready) begin
                r_s_valid <= r_p_valid;
            end
            if (o_free) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (p_ready && i_valid) begin
            r_prod   <= n_prod;
            r_p_fend <= i_fend;
        end
        if (s_ready && r_p_valid) begin
            r_rsum   <= n_rsum;
            r_s_fend <= r_p_fend;
        end
        if (o_free && r_s_valid) begin
            r_o_sum  <= n_total[SUM_W-1:0];
            r_o_fend <= r_s_fend;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.sum       = r_o_sum;
    assign o_res.frame_end = r_o_fend;

endmodule

// ===== design/full_2d_convolution.sv =====
// Top level of the streaming full 2D convolution block.
// Depends on fconv_pkg, fconv_if, fconv_cfg, fconv_front and fconv_mac.
//
//  port      | direction | handshake              | carries
//  ----------+-----------+------------------------+------------------------------
//  i_pix     | in        | valid/ready            | pixel (8 bit)
//  o_res     | out       | valid/ready            | sum (21 bit signed), frame_end
//  APB       | in        | psel/penable, pready=1 | geometry and coefficient regs
//
//  One pixel request per clock sustained while o_res takes results. A request
//  passes stage A, the window stage and the product, row-sum and total stages;
//  the line stores are each read once and written once per clock.
//  After reset the line stores are cleared, MAX_WIDTH+KERNEL_MAX-1 entries
//  (1028 by default); no pixel is taken meanwhile, register writes are.
//  Back-pressure on o_res stalls stage by stage; empty stages still fill.
module full_2d_convolution #(
    parameter int MAX_WIDTH  = fconv_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_MAX = fconv_pkg::KERNEL_MAX_DEF,
    parameter int PIXEL_BITS = fconv_pkg::PIXEL_BITS_DEF,
    parameter int COEFF_BITS = fconv_pkg::COEFF_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fconv_pix_if.sink                        i_pix,
    fconv_res_if.source                      o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fconv_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fconv_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fconv_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import fconv_pkg::*;

    localparam int NTAP = KERNEL_MAX * KERNEL_MAX;

    t_cfg                            cfg;
    logic                            win_valid;
    logic                            win_ready;
    logic [NTAP-1:0][PIXEL_BITS-1:0] win;
    logic [KERNEL_MAX-1:0]           win_jmask;
    logic                            win_fend;

    // Register bank
    fconv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Counters, line stores and window
    fconv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .KERNEL_MAX (KERNEL_MAX),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (cfg),
        .o_valid (win_valid),
        .i_ready (win_ready),
        .o_win   (win),
        .o_jmask (win_jmask),
        .o_fend  (win_fend)
    );

    // Products and sums
    fconv_mac #(
        .KERNEL_MAX (KERNEL_MAX),
        .PIXEL_BITS (PIXEL_BITS),
        .COEFF_BITS (COEFF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (win_valid),
        .o_ready (win_ready),
        .i_win   (win),
        .i_jmask (win_jmask),
        .i_fend  (win_fend),
        .o_res   (o_res)
    );

endmodule
